### hw/rtl/epss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epss_pkg
// Shared types and constants of the extended pattern stream scanner.
// ----------------------------------------------------------------------------
package epss_pkg;

    localparam int WORD_BITS  = 64;
    localparam int ALPHA_SIZE = 256;
    localparam int IDX_W      = $clog2(ALPHA_SIZE);
    localparam int LEN_W      = 7;
    localparam int MBIT_W     = $clog2(WORD_BITS);
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_SCAN  = 2'd0,
        MODE_CLASS = 2'd1,
        MODE_LOOP  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_MARKS     = 2'd0,
        CFG_FINAL_MARKS    = 2'd1,
        CFG_OPTIONAL_MARKS = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_word             init_marks;
        t_word             final_marks;
        t_word             optional_marks;
        logic [LEN_W-1:0]  pattern_length;
    } t_marks;

    typedef struct packed {
        logic scan;
        logic restart;
    } t_step_ctrl;

endpackage

`default_nettype wire

### hw/rtl/extended_pattern_stream_scan_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// extended_pattern_stream_scan_core
// Pipeline: input word -> table read register (with the step control
//   register) -> result register; the state update is combinational.
// Throughput: one word per cycle while m_axis_tready does not stall it.
// Reset: synchronous, clears state vector, config and the table valid bits
//   at once; no clearing pass, words are taken right after reset.
// ----------------------------------------------------------------------------
module extended_pattern_stream_scan_core
    import epss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] text_byte, [15:8] table_index, [79:16] table_word, [80] restart
    input  wire logic [87:0]           s_axis_tdata,
    // [1:0] mode
    input  wire logic [1:0]            s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] match_candidate, [64:1] active_states
    output logic [71:0]                m_axis_tdata,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [WORD_BITS-1:0]  i_cfg_data
);

    logic               in_acc;
    logic               out_adv;
    logic [1:0]         in_mode;
    logic [IDX_W-1:0]   in_text;
    logic [IDX_W-1:0]   in_index;
    t_word              in_word;
    logic               in_restart;

    t_marks             r_marks;
    t_word              r_state;
    logic               r_s1_valid;
    t_step_ctrl         r_s1_ctrl;
    logic               r_out_valid;
    logic               r_out_match;
    t_word              r_out_states;

    t_word              class_word;
    t_word              loop_word;
    t_word              n_state;
    t_word              n_out_states;
    logic               n_out_match;

    assign in_mode    = s_axis_tuser;
    assign in_text    = s_axis_tdata[7:0];
    assign in_index   = s_axis_tdata[15:8];
    assign in_word    = s_axis_tdata[79:16];
    assign in_restart = s_axis_tdata[80];

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    epss_table u_class_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && in_mode == MODE_CLASS),
        .i_wr_addr (in_index),
        .i_wr_data (in_word),
        .i_rd_en   (in_acc && in_mode == MODE_SCAN),
        .i_rd_addr (in_text),
        .o_rd_data (class_word)
    );

    epss_table u_loop_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && in_mode == MODE_LOOP),
        .i_wr_addr (in_index),
        .i_wr_data (in_word),
        .i_rd_en   (in_acc && in_mode == MODE_SCAN),
        .i_rd_addr (in_text),
        .o_rd_data (loop_word)
    );

    epss_update u_update (
        .i_ctrl       (r_s1_ctrl),
        .i_marks      (r_marks),
        .i_state      (r_state),
        .i_class_word (class_word),
        .i_loop_word  (loop_word),
        .o_next_state (n_state),
        .o_states     (n_out_states),
        .o_match      (n_out_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks.init_marks     <= '0;
            r_marks.final_marks    <= '0;
            r_marks.optional_marks <= '0;
            r_marks.pattern_length <= LEN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INIT_MARKS:     r_marks.init_marks     <= i_cfg_data;
                CFG_FINAL_MARKS:    r_marks.final_marks    <= i_cfg_data;
                CFG_OPTIONAL_MARKS: r_marks.optional_marks <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_marks.pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctrl.scan    <= (in_mode == MODE_SCAN);
            r_s1_ctrl.restart <= in_restart;
        end
        if (out_adv && r_s1_valid) begin
            r_out_match  <= n_out_match;
            r_out_states <= n_out_states;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_states, r_out_match};

endmodule

`default_nettype wire

### hw/rtl/epss_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epss_table
// Mask table of ALPHA_SIZE words with per-entry valid bits and a registered
// read port; entries never written read as zero.
// ----------------------------------------------------------------------------
module epss_table
    import epss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [IDX_W-1:0]  i_wr_addr,
    input  wire t_word             i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_addr,
    output t_word                  o_rd_data
);

    t_word                  r_mem [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0]  r_valid;
    t_word                  r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

### hw/rtl/epss_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epss_update
// One Shift-And step: shift, class mask, self loops, optional-run fill and
// match bit select.
// ----------------------------------------------------------------------------
module epss_update
    import epss_pkg::*;
(
    input  wire t_step_ctrl  i_ctrl,
    input  wire t_marks      i_marks,
    input  wire t_word       i_state,
    input  wire t_word       i_class_word,
    input  wire t_word       i_loop_word,
    output t_word            o_next_state,
    output t_word            o_states,
    output logic             o_match
);

    t_word              d_prev;
    t_word              d_step;
    t_word              d_fin;
    t_word              d_fill;
    logic [MBIT_W-1:0]  mbit;

    always_comb begin
        d_prev = i_ctrl.restart ? '0 : i_state;
        d_step = (((d_prev << 1) | t_word'(1)) & i_class_word) | (d_prev & i_loop_word);
        d_fin  = d_step | i_marks.final_marks;
        d_fill = d_step | (i_marks.optional_marks & (~(d_fin - i_marks.init_marks) ^ d_fin));

        if (i_marks.pattern_length == '0) begin
            mbit = '0;
        end else if (i_marks.pattern_length > LEN_W'(WORD_BITS)) begin
            mbit = MBIT_W'(WORD_BITS - 1);
        end else begin
            mbit = MBIT_W'(i_marks.pattern_length - LEN_W'(1));
        end

        o_next_state = i_ctrl.scan ? d_fill : i_state;
        o_states     = i_ctrl.scan ? d_fill : '0;
        o_match      = i_ctrl.scan & d_fill[mbit];
    end

endmodule

`default_nettype wire
